FILE: hw/rtl/mm4_pkg.sv
package mm4_pkg;

   localparam int unsigned DIM  = 4;
   localparam int unsigned SIZE = 16;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_LOAD_LEFT   = 2'd0;
   localparam logic [1:0] KIND_LOAD_RIGHT  = 2'd1;
   localparam logic [1:0] KIND_MUL         = 2'd2;
   localparam logic [1:0] KIND_MUL_INPLACE = 2'd3;

   localparam logic [3:0]  LAST_INDEX = 4'd15;
   localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN    = 32'h8000_0000;

   // Sequencer program steps
   localparam logic [2:0] STEP_IDLE  = 3'd0;
   localparam logic [2:0] STEP_MAC0  = 3'd1;
   localparam logic [2:0] STEP_MAC1  = 3'd2;
   localparam logic [2:0] STEP_MAC2  = 3'd3;
   localparam logic [2:0] STEP_MAC3  = 3'd4;
   localparam logic [2:0] STEP_DRAIN = 3'd5;
   localparam logic [2:0] STEP_FLIP  = 3'd6;

   // Next-step conditions
   localparam logic [2:0] COND_START  = 3'd0;
   localparam logic [2:0] COND_NEXT   = 3'd1;
   localparam logic [2:0] COND_ELEM   = 3'd2;
   localparam logic [2:0] COND_DRAIN  = 3'd3;
   localparam logic [2:0] COND_ALWAYS = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  index;
      logic [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  index_res;
      logic [31:0] value_res;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic       issue;
      logic [1:0] k;
      logic       elem_inc;
      logic       flip;
      logic [2:0] cond;
      logic [2:0] target;
   } uword_type;

   typedef struct packed {
      logic       issue;
      logic [1:0] k;
      logic [3:0] elem;
      logic       flip;
   } seq_ctl_type;

   typedef struct packed {
      logic busy;
      logic stall;
   } dp_stat_type;

   typedef struct packed {
      logic        we_left;
      logic        we_right;
      logic [3:0]  index;
      logic [31:0] value;
   } load_type;

   function automatic uword_type useq_rom(input logic [2:0] step);
      uword_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.cond   = COND_START;
            w.target = STEP_MAC0;
         end
         STEP_MAC0: begin
            w.issue = 1'b1;
            w.k     = 2'd0;
            w.cond  = COND_NEXT;
         end
         STEP_MAC1: begin
            w.issue = 1'b1;
            w.k     = 2'd1;
            w.cond  = COND_NEXT;
         end
         STEP_MAC2: begin
            w.issue = 1'b1;
            w.k     = 2'd2;
            w.cond  = COND_NEXT;
         end
         STEP_MAC3: begin
            w.issue    = 1'b1;
            w.k        = 2'd3;
            w.elem_inc = 1'b1;
            w.cond     = COND_ELEM;
            w.target   = STEP_MAC0;
         end
         STEP_DRAIN: begin
            w.cond = COND_DRAIN;
         end
         STEP_FLIP: begin
            w.flip   = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/mm4_req_if.sv
interface mm4_req_if;
   import mm4_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mm4_rsp_if.sv
interface mm4_rsp_if;
   import mm4_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mm4_useq.sv
module mm4_useq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 inplace,
   input  mm4_pkg::dp_stat_type stat,
   output mm4_pkg::seq_ctl_type ctl,
   output logic                 idle
);
   import mm4_pkg::*;

   logic [2:0] step_ff, step_in;
   logic [3:0] elem_ff, elem_in;
   logic       inplace_ff, inplace_in;
   uword_type  uw;
   logic       adv;

   assign uw  = useq_rom(step_ff);
   assign adv = !stat.stall;

   always_comb begin
      step_in    = step_ff;
      elem_in    = elem_ff;
      inplace_in = inplace_ff;
      unique case (uw.cond)
         COND_START: begin
            if (start) begin
               step_in    = uw.target;
               elem_in    = '0;
               inplace_in = inplace;
            end
         end
         COND_NEXT: begin
            if (adv) step_in = step_ff + 3'd1;
         end
         COND_ELEM: begin
            if (adv) step_in = (elem_ff != LAST_INDEX) ? uw.target : step_ff + 3'd1;
         end
         COND_DRAIN: begin
            // hold until the last product is written back
            if (adv && !stat.busy) step_in = step_ff + 3'd1;
         end
         COND_ALWAYS: begin
            if (adv) step_in = uw.target;
         end
         default: step_in = STEP_IDLE;
      endcase
      if (adv && uw.elem_inc) elem_in = elem_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_IDLE;
         elem_ff    <= '0;
         inplace_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         elem_ff    <= elem_in;
         inplace_ff <= inplace_in;
      end
   end

   assign ctl.issue = uw.issue && adv;
   assign ctl.k     = uw.k;
   assign ctl.elem  = elem_ff;
   assign ctl.flip  = uw.flip && inplace_ff && adv;
   assign idle      = (step_ff == STEP_IDLE);

endmodule

FILE: hw/rtl/mm4_dp.sv
module mm4_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mm4_pkg::seq_ctl_type ctl,
   input  mm4_pkg::load_type    load,
   mm4_rsp_if.source            rsp,
   output mm4_pkg::dp_stat_type stat
);
   import mm4_pkg::*;

   // Left matrix is double-banked: products land in the idle bank and an
   // in-place multiply just swaps banks at the end.
   logic [31:0]        lmem [0:31];
   logic [31:0]        rmem [0:15];
   logic [31:0]        lvld_ff;
   logic [15:0]        rvld_ff;
   logic               bank_ff;

   logic               stall;
   logic               adv;
   logic [4:0]         laddr;
   logic [3:0]         raddr;

   logic               v1_ff, v2_ff, v3_ff;
   logic               first1_ff, first2_ff;
   logic               last1_ff, last2_ff, last3_ff;
   logic [3:0]         elem1_ff, elem2_ff, elem3_ff;
   logic signed [31:0] lrd_ff, rrd_ff;
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [65:0] prod_ext;
   logic [31:0]        sat;
   logic               wb_en;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;

   assign stall = rsp_valid_ff && !rsp.ready;
   assign adv   = !stall;
   assign laddr = {bank_ff, ctl.elem[3:2], ctl.k};
   assign raddr = {ctl.k, ctl.elem[1:0]};

   // read stage
   always_ff @(posedge clock) begin
      if (adv) begin
         lrd_ff <= lvld_ff[laddr] ? lmem[laddr] : '0;
         rrd_ff <= rvld_ff[raddr] ? rmem[raddr] : '0;
      end
   end

   // multiply and accumulate stages
   assign prod_ext = 66'(prod_ff);
   assign acc_in   = first2_ff ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (adv) begin
         first1_ff <= (ctl.k == 2'd0);
         last1_ff  <= (ctl.k == 2'd3);
         elem1_ff  <= ctl.elem;
         prod_ff   <= lrd_ff * rrd_ff;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         elem2_ff  <= elem1_ff;
         acc_ff    <= acc_in;
         last3_ff  <= last2_ff;
         elem3_ff  <= elem2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= ctl.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // drop the low 16 bits, then saturate to 32 bits
   always_comb begin
      if (acc_ff[65:47] == {19{acc_ff[47]}}) sat = acc_ff[47:16];
      else if (acc_ff[65])                   sat = SAT_MIN;
      else                                   sat = SAT_MAX;
   end

   assign wb_en = v3_ff && last3_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v3_ff && last3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         rsp_payload_ff.index_res <= elem3_ff;
         rsp_payload_ff.value_res <= sat;
         rsp_payload_ff.last      <= (elem3_ff == LAST_INDEX);
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;

   // memory writes: product writeback into the idle bank, or element loads
   always_ff @(posedge clock) begin
      if (wb_en) begin
         lmem[{~bank_ff, elem3_ff}] <= sat;
      end else if (load.we_left) begin
         lmem[{bank_ff, load.index}] <= load.value;
      end
      if (load.we_right) begin
         rmem[load.index] <= load.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvld_ff <= '0;
         rvld_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         if (wb_en) begin
            lvld_ff[{~bank_ff, elem3_ff}] <= 1'b1;
         end else if (load.we_left) begin
            lvld_ff[{bank_ff, load.index}] <= 1'b1;
         end
         if (load.we_right) begin
            rvld_ff[load.index] <= 1'b1;
         end
         if (ctl.flip) begin
            bank_ff <= ~bank_ff;
         end
      end
   end

   assign stat.busy  = v1_ff || v2_ff || v3_ff;
   assign stat.stall = stall;

endmodule

FILE: hw/rtl/matrix_multiply_4x4_top.sv
// Load items are accepted back to back while the block is idle.
// A multiply item occupies the block until its last product is written back;
// results leave one per element, paced by the single shared 32x32 multiplier
// doing four products per element.
// Output backpressure freezes the sequencer and the whole pipeline.
// Synchronous reset clears both matrices to zero through per-entry valid bits.
module matrix_multiply_4x4_top (
   input  logic      clock,
   input  logic      reset,
   mm4_req_if.sink   req_ch,
   mm4_rsp_if.source rsp_ch
);
   import mm4_pkg::*;

   seq_ctl_type ctl;
   dp_stat_type stat;
   load_type    load;
   logic        idle;
   logic        req_xfer;
   logic        start;
   logic        inplace;

   assign req_ch.ready = idle;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign inplace      = (req_ch.payload.kind == KIND_MUL_INPLACE);
   assign start        = req_xfer && ((req_ch.payload.kind == KIND_MUL) || inplace);

   assign load.we_left  = req_xfer && (req_ch.payload.kind == KIND_LOAD_LEFT);
   assign load.we_right = req_xfer && (req_ch.payload.kind == KIND_LOAD_RIGHT);
   assign load.index    = req_ch.payload.index;
   assign load.value    = req_ch.payload.value;

   mm4_useq u_useq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .inplace (inplace),
      .stat    (stat),
      .ctl     (ctl),
      .idle    (idle)
   );

   mm4_dp u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .load  (load),
      .rsp   (rsp_ch),
      .stat  (stat)
   );

   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !stat.busy)
      else $error("request accepted while products are still in flight");

   a_flip_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.flip |-> (!stat.busy && !ctl.issue))
      else $error("bank swap before writeback finished");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.last) |-> (rsp_ch.payload.index_res == LAST_INDEX))
      else $error("last marker on wrong element");

   a_issue_running: assert property (@(posedge clock) disable iff (reset)
      ctl.issue |=> !idle)
      else $error("sequencer idle right after issuing a product");

endmodule

FILE: tb/matrix_multiply_4x4_top_test.sv
module matrix_multiply_4x4_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mm4_pkg::*;

   localparam logic signed [67:0] ELEM_MAX = 68'sh0_0000_0000_7FFF_FFFF;
   localparam logic signed [67:0] ELEM_MIN = -68'sh0_0000_0000_8000_0000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 100;

   logic clock;
   logic reset;

   mm4_req_if req_bus();
   mm4_rsp_if rsp_bus();

   matrix_multiply_4x4_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Predicted state of the two operand stores
   logic signed [31:0] left_store  [SIZE];
   logic signed [31:0] right_store [SIZE];

   rsp_payload_type expected_products[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;
   int error_count    = 0;
   int transfers_sent = 0;
   int multiplies     = 0;
   int elements_seen  = 0;

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout at %0t, %0d product elements still pending", $time,
               expected_products.size());
      $display("matrix_multiply_4x4_top: mismatch");
      $finish;
   end

   // Receiver side: random stalls, or a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic logic [31:0] product_element(input logic [1:0] row,
                                                   input logic [1:0] col);
      logic signed [67:0] acc;
      logic signed [67:0] lhs;
      logic signed [67:0] rhs;
      logic signed [67:0] shifted;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         lhs = left_store[{row, 2'(k)}];
         rhs = right_store[{2'(k), col}];
         acc = acc + lhs * rhs;
      end
      // floor division by 2^16, then clamp to 32 bits
      shifted = acc >>> 16;
      if (shifted > ELEM_MAX) begin
         return SAT_MAX;
      end else if (shifted < ELEM_MIN) begin
         return SAT_MIN;
      end
      return shifted[31:0];
   endfunction

   function automatic void apply_request(input req_payload_type item);
      logic signed [31:0] product [SIZE];
      rsp_payload_type    elem;
      case (item.kind)
         KIND_LOAD_LEFT: begin
            left_store[item.index] = item.value;
         end
         KIND_LOAD_RIGHT: begin
            right_store[item.index] = item.value;
         end
         default: begin
            multiplies++;
            for (int i = 0; i < SIZE; i++) begin
               product[i]     = product_element(2'(i / DIM), 2'(i % DIM));
               elem.index_res = 4'(i);
               elem.value_res = product[i];
               elem.last      = (4'(i) == LAST_INDEX);
               expected_products.push_back(elem);
            end
            // replace left only after the whole product is formed
            if (item.kind == KIND_MUL_INPLACE) begin
               for (int i = 0; i < SIZE; i++) begin
                  left_store[i] = product[i];
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         elements_seen++;
         if (expected_products.size() == 0) begin
            $display("%0t: unexpected product element index %0d value %h last %b",
                     $time, got.index_res, got.value_res, got.last);
            error_count++;
         end else begin
            want = expected_products.pop_front();
            if (got.index_res !== want.index_res) begin
               $display("%0t: index_res expected %0d actual %0d", $time,
                        want.index_res, got.index_res);
               error_count++;
            end
            if (got.value_res !== want.value_res) begin
               $display("%0t: value_res at %0d expected %h actual %h", $time,
                        want.index_res, want.value_res, got.value_res);
               error_count++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last at %0d expected %b actual %b", $time,
                        want.index_res, want.last, got.last);
               error_count++;
            end
         end
      end
   end

   function automatic logic [31:0] random_q16();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 6))
               0: return SAT_MAX;
               1: return SAT_MIN;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return 32'h0000_0001;
               5: return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
         2: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
         default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      endcase
   endfunction

   // Leaves valid high on return so back-to-back items need no second assignment
   task automatic send_item(input logic [1:0] kind, input logic [3:0] index,
                            input logic [31:0] value);
      req_payload_type item;
      item.kind  = kind;
      item.index = index;
      item.value = value;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do @(posedge clock); while (!req_bus.ready);
      apply_request(item);
      transfers_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_products.size() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_reset_state();
      // product of the cleared stores; index and value of a multiply are ignored
      send_item(KIND_MUL, 4'hF, 32'hFFFF_FFFF);
   endtask

   task automatic test_directed_extremes();
      for (int i = 0; i < DIM; i++) begin
         send_item(KIND_LOAD_LEFT, 4'(i), SAT_MAX);
      end
      for (int i = 0; i < DIM; i++) begin
         send_item(KIND_LOAD_RIGHT, 4'(i * DIM), SAT_MAX);
      end
      // saturate low through max * min, truncate -1 * max toward minus infinity
      send_item(KIND_LOAD_RIGHT, 4'd1, SAT_MIN);
      send_item(KIND_LOAD_LEFT, 4'd4, 32'hFFFF_FFFF);
      send_item(KIND_LOAD_LEFT, 4'd15, 32'h0001_8000);
      send_item(KIND_LOAD_RIGHT, 4'd15, 32'h0001_0000);
      send_item(KIND_MUL, 4'h0, 32'h0000_0000);
      // chain: the second product uses the replaced left store
      send_item(KIND_MUL_INPLACE, 4'h5, 32'h1234_5678);
      send_item(KIND_MUL, 4'hA, 32'h8765_4321);
      send_item(KIND_MUL_INPLACE, 4'h0, 32'h0000_0000);
   endtask

   task automatic test_random_phase(input int count, input int send_pct,
                                    input int stall_pct);
      int choice;
      logic [3:0] idx;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         choice = $urandom_range(0, 99);
         idx    = 4'($urandom_range(0, 15));
         if (choice < 30) begin
            send_item(KIND_LOAD_LEFT, idx, random_q16());
         end else if (choice < 60) begin
            send_item(KIND_LOAD_RIGHT, idx, random_q16());
         end else if (choice < 85) begin
            send_item(KIND_MUL, idx, $urandom);
         end else begin
            send_item(KIND_MUL_INPLACE, idx, $urandom);
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // hold the result side while requests keep coming, so the input stalls
      hold_cycles = HOLD_OFF_CYCLES;
      send_item(KIND_LOAD_LEFT, 4'd2, random_q16());
      send_item(KIND_MUL, 4'd0, $urandom);
      send_item(KIND_LOAD_RIGHT, 4'd9, random_q16());
      send_item(KIND_MUL_INPLACE, 4'd0, $urandom);
      send_item(KIND_LOAD_LEFT, 4'd7, random_q16());
      send_item(KIND_MUL, 4'd0, $urandom);
      send_item(KIND_MUL, 4'd0, $urandom);
      wait_drained();
      send_item(KIND_LOAD_RIGHT, 4'd3, random_q16());
      send_item(KIND_MUL, 4'd0, $urandom);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      for (int i = 0; i < SIZE; i++) begin
         left_store[i]  = '0;
         right_store[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed_extremes();
      test_random_phase(60, 0, 0);
      test_random_phase(60, 61, 0);
      test_random_phase(60, 0, 61);
      test_random_phase(60, 32, 32);
      test_backpressure();

      recv_stall_pct = 0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_products.size() != 0) begin
         $display("%0t: %0d product elements never arrived", $time,
                  expected_products.size());
         error_count++;
      end

      $display("run covered %0d request transfers and %0d multiplies, %0d elements checked",
               transfers_sent, multiplies, elements_seen);
      $display("phases: saturation and truncation, chained in-place, idle and stall mixes");
      if (error_count == 0) begin
         $display("matrix_multiply_4x4_top: match");
      end else begin
         $display("matrix_multiply_4x4_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: matrix_multiply_4x4_top.f
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_req_if.sv
hw/rtl/mm4_rsp_if.sv
hw/rtl/mm4_useq.sv
hw/rtl/mm4_dp.sv
hw/rtl/matrix_multiply_4x4_top.sv
tb/matrix_multiply_4x4_top_test.sv
